// ===== hw/rtl/wpu_pkg.sv =====
package wpu_pkg;

  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned DIV_W     = 32 + FRAC_BITS;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_SIZE = 32'd16;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_SMP = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [3:0] ERR_RIFF    = 4'd0;
  localparam logic [3:0] ERR_WAVE    = 4'd1;
  localparam logic [3:0] ERR_FMT     = 4'd2;
  localparam logic [3:0] ERR_FMTSIZE = 4'd3;
  localparam logic [3:0] ERR_DATA    = 4'd4;
  localparam logic [3:0] ERR_NOTPCM  = 4'd5;
  localparam logic [3:0] ERR_CHANS   = 4'd6;
  localparam logic [3:0] ERR_BITS    = 4'd7;
  localparam logic [3:0] ERR_FRAME   = 4'd8;
  localparam logic [3:0] ERR_RATE    = 4'd9;
  localparam logic [3:0] ERR_PARTIAL = 4'd10;
  localparam logic [3:0] ERR_TRUNC   = 4'd11;

  typedef struct packed {
    logic load;
    logic step;
    logic sel_second;
  } wpu_cmd_t;

  typedef struct packed {
    logic no_res;
    logic smp;
    logic div_done;
    logic two;
  } wpu_sts_t;

endpackage

// ===== hw/rtl/wpu_if.sv =====
interface wpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface wpu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        channel;
  logic [31:0] raw_sample;
  logic signed [31:0] scaled_value;
  logic [3:0]  error_code;
  logic [1:0]  channel_count;
  logic [5:0]  bits_per_sample;
  logic [31:0] sample_rate;
  logic        final_res;
  modport source (output valid, output kind, output channel, output raw_sample,
                  output scaled_value, output error_code, output channel_count,
                  output bits_per_sample, output sample_rate, output final_res,
                  input ready);
  modport sink (input valid, input kind, input channel, input raw_sample,
                input scaled_value, input error_code, input channel_count,
                input bits_per_sample, input sample_rate, input final_res,
                output ready);
endinterface

// ===== hw/rtl/wpu_datapath.sv =====
module wpu_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpu_pkg::wpu_cmd_t cmd_i,
  output wpu_pkg::wpu_sts_t sts_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output logic [1:0]        kind_o,
  output logic              channel_o,
  output logic [31:0]       raw_sample_o,
  output logic signed [31:0] scaled_value_o,
  output logic [3:0]        error_code_o,
  output logic [1:0]        channel_count_o,
  output logic [5:0]        bits_per_sample_o,
  output logic [31:0]       sample_rate_o,
  output logic              final_res_o
);
  import wpu_pkg::*;

  typedef enum logic [1:0] {
    M_HEADER = 2'd0,
    M_DATA   = 2'd1,
    M_HALT   = 2'd2
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] fmt_q, fmt_d, chan_q, chan_d, frame_q, frame_d, width_q, width_d;
  logic [31:0] rate_q, rate_d, brate_q, brate_d, accum_q, accum_d;
  logic [1:0]  bis_q, bis_d;
  logic        chi_q, chi_d;

  logic [7:0]  byte_q;
  logic        eos_q;

  // staged result
  logic [1:0]  k0_q;
  logic [3:0]  e0_q;
  logic        ch0_q;
  logic [31:0] raw0_q, rate0_q;
  logic [1:0]  cc0_q;
  logic [5:0]  bits0_q;
  logic        two_q;

  // divide by 2^k-1: fold the chunks above bit k back into the remainder
  logic             busy_q;
  logic [1:0]       sh_q;
  logic [31:0]      quo_q, m_q;
  logic [DIV_W-1:0] rem_q;
  logic             neg_q;
  logic [31:0]      div_hi, div_lo;
  logic             div_last;

  // header evaluation
  logic        h_err, h_acc;
  logic [3:0]  h_code;
  logic [31:0] prod_cw, prod_fr;

  // data evaluation
  logic [2:0]  nbytes;
  logic [31:0] acc_n;
  logic        complete;
  logic [1:0]  bis_n;
  logic        chi_n;
  logic        partial;
  logic [31:0] m_n, mag_n;

  logic        r_hdr, r_err, r_smp, r_two;

  assign prod_cw = {16'd0, chan_q} * {16'd0, width_q};
  assign prod_fr = 32'(frame_q * rate_q);

  always_comb begin
    shift_d = {byte_q, shift_q[31:8]};
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    brate_d = brate_q;
    frame_d = frame_q;
    width_d = width_q;
    h_err   = 1'b0;
    h_acc   = 1'b0;
    h_code  = ERR_RIFF;
    case (cnt_q)
      6'd3:  if (shift_d != TAG_RIFF) begin h_err = 1'b1; h_code = ERR_RIFF; end
      6'd11: if (shift_d != TAG_WAVE) begin h_err = 1'b1; h_code = ERR_WAVE; end
      6'd15: if (shift_d != TAG_FMT) begin h_err = 1'b1; h_code = ERR_FMT; end
      6'd19: if (shift_d != FMT_SIZE) begin h_err = 1'b1; h_code = ERR_FMTSIZE; end
      6'd21: fmt_d = shift_d[31:16];
      6'd23: chan_d = shift_d[31:16];
      6'd27: rate_d = shift_d;
      6'd31: brate_d = shift_d;
      6'd33: frame_d = shift_d[31:16];
      6'd35: width_d = shift_d[31:16];
      6'd39: if (shift_d != TAG_DATA) begin h_err = 1'b1; h_code = ERR_DATA; end
      6'd43: begin
        h_err = 1'b1;
        if (fmt_q != 16'd1) h_code = ERR_NOTPCM;
        else if (chan_q != 16'd1 && chan_q != 16'd2) h_code = ERR_CHANS;
        else if (width_q != 16'd8 && width_q != 16'd16 &&
                 width_q != 16'd24 && width_q != 16'd32) h_code = ERR_BITS;
        else if ({16'd0, frame_q} != {3'd0, prod_cw[31:3]}) h_code = ERR_FRAME;
        else if (brate_q != prod_fr) h_code = ERR_RATE;
        else begin
          h_err = 1'b0;
          h_acc = 1'b1;
        end
      end
      default: ;
    endcase
    if (!h_err && !h_acc && eos_q) begin
      h_err  = 1'b1;
      h_code = ERR_TRUNC;
    end
  end

  always_comb begin
    nbytes   = width_q[5:3];
    acc_n    = accum_q | ({24'd0, byte_q} << {bis_q, 3'b000});
    complete = ({1'b0, bis_q} + 3'd1) >= nbytes;
    bis_n    = complete ? 2'd0 : bis_q + 2'd1;
    chi_n    = complete ? ((chan_q == 16'd2) ? ~chi_q : 1'b0) : chi_q;
    partial  = eos_q && (bis_n != 2'd0 || chi_n);
    case (nbytes)
      3'd1:    m_n = 32'h0000_007F;
      3'd2:    m_n = 32'h0000_7FFF;
      3'd3:    m_n = 32'h007F_FFFF;
      default: m_n = 32'h7FFF_FFFF;
    endcase
    mag_n = (acc_n <= m_n) ? m_n - acc_n : acc_n - m_n;
  end

  always_comb begin
    r_hdr = 1'b0;
    r_err = 1'b0;
    r_smp = 1'b0;
    r_two = 1'b0;
    if (mode_q == M_HEADER) begin
      r_err = h_err;
      r_hdr = h_acc;
    end else if (mode_q == M_DATA) begin
      r_smp = complete;
      r_err = partial && !complete;
      r_two = partial && complete;
    end
  end

  always_comb begin
    case (sh_q)
      2'd0:    div_hi = 32'(rem_q >> 7);
      2'd1:    div_hi = 32'(rem_q >> 15);
      2'd2:    div_hi = 32'(rem_q >> 23);
      default: div_hi = 32'(rem_q >> 31);
    endcase
    div_lo   = rem_q[31:0] & m_q;
    div_last = (div_hi == 32'd0) && (rem_q[31:0] != m_q);
  end

  assign sts_o.no_res   = !(r_hdr || r_err || r_smp);
  assign sts_o.smp      = r_smp;
  assign sts_o.div_done = !busy_q;
  assign sts_o.two      = two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_HEADER;
      cnt_q   <= '0;
      shift_q <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      brate_q <= '0;
      frame_q <= '0;
      width_q <= '0;
      accum_q <= '0;
      bis_q   <= '0;
      chi_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        if (eos_q) begin
          mode_q  <= M_HEADER;
          cnt_q   <= '0;
          shift_q <= '0;
          fmt_q   <= '0;
          chan_q  <= '0;
          rate_q  <= '0;
          brate_q <= '0;
          frame_q <= '0;
          width_q <= '0;
          accum_q <= '0;
          bis_q   <= '0;
          chi_q   <= 1'b0;
        end else if (mode_q == M_HEADER) begin
          shift_q <= shift_d;
          fmt_q   <= fmt_d;
          chan_q  <= chan_d;
          rate_q  <= rate_d;
          brate_q <= brate_d;
          frame_q <= frame_d;
          width_q <= width_d;
          cnt_q   <= cnt_q + 6'd1;
          if (h_err) begin
            mode_q <= M_HALT;
          end else if (h_acc) begin
            mode_q  <= M_DATA;
            accum_q <= '0;
            bis_q   <= '0;
            chi_q   <= 1'b0;
          end
        end else if (mode_q == M_DATA) begin
          accum_q <= complete ? 32'd0 : acc_n;
          bis_q   <= bis_n;
          chi_q   <= chi_n;
        end
        if (r_smp) begin
          busy_q <= 1'b1;
        end
      end else if (busy_q && div_last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
    if (cmd_i.step) begin
      k0_q    <= r_smp ? KIND_SMP : (r_hdr ? KIND_HDR : KIND_ERR);
      e0_q    <= (mode_q == M_HEADER) ? (h_err ? h_code : ERR_RIFF) :
                 ((r_err) ? ERR_PARTIAL : ERR_RIFF);
      ch0_q   <= r_smp ? chi_q : 1'b0;
      raw0_q  <= r_smp ? acc_n : 32'd0;
      cc0_q   <= r_hdr ? chan_q[1:0] : 2'd0;
      bits0_q <= r_hdr ? width_q[5:0] : 6'd0;
      rate0_q <= r_hdr ? rate_q : 32'd0;
      two_q   <= r_two;
      quo_q   <= '0;
      m_q     <= m_n;
      sh_q    <= 2'(nbytes - 3'd1);
      neg_q   <= acc_n > m_n;
      rem_q   <= {mag_n, {FRAC_BITS{1'b0}}};
    end else if (busy_q) begin
      if (div_hi != 32'd0) begin
        quo_q <= quo_q + div_hi;
        rem_q <= {{(DIV_W - 32){1'b0}}, div_hi + div_lo};
      end else if (rem_q[31:0] == m_q) begin
        quo_q <= quo_q + 32'd1;
        rem_q <= '0;
      end
    end
  end

  always_comb begin
    if (cmd_i.sel_second) begin
      kind_o            = KIND_ERR;
      channel_o         = 1'b0;
      raw_sample_o      = '0;
      scaled_value_o    = '0;
      error_code_o      = ERR_PARTIAL;
      channel_count_o   = '0;
      bits_per_sample_o = '0;
      sample_rate_o     = '0;
      final_res_o       = 1'b1;
    end else begin
      kind_o            = k0_q;
      channel_o         = ch0_q;
      raw_sample_o      = raw0_q;
      scaled_value_o    = (k0_q == KIND_SMP) ? (neg_q ? -quo_q : quo_q) : 32'sd0;
      error_code_o      = e0_q;
      channel_count_o   = cc0_q;
      bits_per_sample_o = bits0_q;
      sample_rate_o     = rate0_q;
      final_res_o       = !two_q;
    end
  end

endmodule

// ===== hw/rtl/wpu_ctrl.sv =====
module wpu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wpu_pkg::wpu_cmd_t cmd_o,
  input  wpu_pkg::wpu_sts_t sts_i
);
  import wpu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_OUT0,
    S_OUT1
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT0) || (state_q == S_OUT1);
  assign cmd_o.load       = in_valid_i && in_ready_o;
  assign cmd_o.step       = (state_q == S_EVAL);
  assign cmd_o.sel_second = (state_q == S_OUT1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EVAL;
      S_EVAL: begin
        if (sts_i.no_res) state_d = S_IDLE;
        else if (sts_i.smp) state_d = S_DIV;
        else state_d = S_OUT0;
      end
      S_DIV:  if (sts_i.div_done) state_d = S_OUT0;
      S_OUT0: if (out_ready_i) state_d = sts_i.two ? S_OUT1 : S_IDLE;
      S_OUT1: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/wav_pcm_header_and_sample_unpacker_core.sv =====
// Takes a WAV file one byte per item, checks the 44-byte PCM header, then
// unpacks little-endian samples into raw codes and Q2.30 values. A byte that
// gives no result is done once evaluated; a header or error result adds the
// output handshake. A byte that completes a sample also waits for the divide
// by 2^(bits-1)-1, which folds the dividend back on itself in (bits-1)-wide
// chunks, one fold per cycle, and then for the output handshake. A partial-frame
// error after a sample is a second result item.
module wav_pcm_header_and_sample_unpacker_core (
  input logic clk_i,
  input logic rst_ni,
  wpu_in_if.sink    in_i,
  wpu_out_if.source out_o
);
  import wpu_pkg::*;

  wpu_cmd_t cmd;
  wpu_sts_t sts;

  wpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wpu_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .data_byte_i       (in_i.data_byte),
    .end_of_stream_i   (in_i.end_of_stream),
    .kind_o            (out_o.kind),
    .channel_o         (out_o.channel),
    .raw_sample_o      (out_o.raw_sample),
    .scaled_value_o    (out_o.scaled_value),
    .error_code_o      (out_o.error_code),
    .channel_count_o   (out_o.channel_count),
    .bits_per_sample_o (out_o.bits_per_sample),
    .sample_rate_o     (out_o.sample_rate),
    .final_res_o       (out_o.final_res)
  );

endmodule

// ===== hw/rtl/wpu_checker.sv =====
module wpu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic       final_i
);
  import wpu_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("out item dropped");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while result pending");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken without evaluation");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !final_i |-> kind_i == KIND_SMP)
    else $error("non-final item is not a sample");

endmodule

bind wav_pcm_header_and_sample_unpacker_core wpu_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .final_i     (out_o.final_res)
);
